// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the buddy block allocator: field
// widths, result codes, the datapath command set and the status bundle.
// ----------------------------------------------------------------------------
package bba_pkg;

	// default geometry
	localparam int MIN_BLOCK_DEF  = 4;
	localparam int LEAF_COUNT_DEF = 256;

	// field widths
	localparam int SIZE_W   = 11;
	localparam int OFF_W    = 10;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 4;

	// reset value of the pool order register
	localparam logic [CFG_W-1:0] POOL_ORDER_RST = 4'd8;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

	// request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// commands from the controller to the datapath
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_CLR_STEP,
		CMD_LOAD,
		CMD_PREP,
		CMD_NEXT_ADDR,
		CMD_A_INIT,
		CMD_A_NEXT_ORD,
		CMD_A_TAKE,
		CMD_A_SPLIT,
		CMD_F_ANC_INIT,
		CMD_F_ANC_NEXT,
		CMD_F_DESC_INIT,
		CMD_F_DESC_NEXT_ORD,
		CMD_F_MRG_INIT,
		CMD_F_MRG_STEP,
		CMD_F_SET,
		CMD_RES_ALLOC,
		CMD_RES_NOFIT,
		CMD_RES_BAD
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic req_free;
		logic size_ok;
		logic free_bad;
		logic rd_free;
		logic at_last;
		logic ord_eq_p;
		logic ord_gt_k;
		logic desc_last_ord;
		logic k_zero;
		logic clr_done;
	} dp_stat_t;

	// tree height: largest h with 2^h leaves available
	function automatic int tree_h(input int leaves);
		int h;
		h = 0;
		for (int i = 0; i < 20; i++) begin
			if ((2 << i) <= leaves) begin
				h = i + 1;
			end
		end
		return h;
	endfunction

endpackage

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: walks the clearing sweep, the allocate search
// and split, and the free checks and merge, issuing one command a cycle.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_we,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_DECIDE,
		S_A_RD,
		S_A_CHK,
		S_A_SPLIT,
		S_F_ANC_RD,
		S_F_ANC_CHK,
		S_F_DESC_RD,
		S_F_DESC_CHK,
		S_F_MRG_TEST,
		S_F_MRG_CHK
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd     = bba_pkg::CMD_NOP;
		done_d  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd = bba_pkg::CMD_CLR_STEP;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd     = bba_pkg::CMD_LOAD;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd     = bba_pkg::CMD_PREP;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.req_free) begin
					if (stat.size_ok) begin
						cmd     = bba_pkg::CMD_A_INIT;
						state_d = S_A_RD;
					end else begin
						cmd     = bba_pkg::CMD_RES_BAD;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else if (stat.free_bad) begin
					cmd     = bba_pkg::CMD_RES_BAD;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd     = bba_pkg::CMD_F_ANC_INIT;
					state_d = S_F_ANC_RD;
				end
			end
			// allocate: scan each order for the lowest free node
			S_A_RD: begin
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				if (stat.rd_free) begin
					cmd     = bba_pkg::CMD_A_TAKE;
					state_d = S_A_SPLIT;
				end else if (stat.at_last) begin
					if (stat.ord_eq_p) begin
						cmd     = bba_pkg::CMD_RES_NOFIT;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd     = bba_pkg::CMD_A_NEXT_ORD;
						state_d = S_A_RD;
					end
				end else begin
					cmd     = bba_pkg::CMD_NEXT_ADDR;
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				if (stat.ord_gt_k) begin
					cmd = bba_pkg::CMD_A_SPLIT;
				end else begin
					cmd     = bba_pkg::CMD_RES_ALLOC;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			// free: no enclosing block may be free
			S_F_ANC_RD: begin
				state_d = S_F_ANC_CHK;
			end
			S_F_ANC_CHK: begin
				if (stat.rd_free) begin
					cmd     = bba_pkg::CMD_RES_BAD;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (stat.ord_eq_p) begin
					if (stat.k_zero) begin
						cmd     = bba_pkg::CMD_F_MRG_INIT;
						state_d = S_F_MRG_TEST;
					end else begin
						cmd     = bba_pkg::CMD_F_DESC_INIT;
						state_d = S_F_DESC_RD;
					end
				end else begin
					cmd     = bba_pkg::CMD_F_ANC_NEXT;
					state_d = S_F_ANC_RD;
				end
			end
			// free: no block inside may be free
			S_F_DESC_RD: begin
				state_d = S_F_DESC_CHK;
			end
			S_F_DESC_CHK: begin
				if (stat.rd_free) begin
					cmd     = bba_pkg::CMD_RES_BAD;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (stat.at_last) begin
					if (stat.desc_last_ord) begin
						cmd     = bba_pkg::CMD_F_MRG_INIT;
						state_d = S_F_MRG_TEST;
					end else begin
						cmd     = bba_pkg::CMD_F_DESC_NEXT_ORD;
						state_d = S_F_DESC_RD;
					end
				end else begin
					cmd     = bba_pkg::CMD_NEXT_ADDR;
					state_d = S_F_DESC_RD;
				end
			end
			// free: merge with free buddies upward
			S_F_MRG_TEST: begin
				if (stat.ord_eq_p) begin
					cmd     = bba_pkg::CMD_F_SET;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_F_MRG_CHK;
				end
			end
			S_F_MRG_CHK: begin
				if (stat.rd_free) begin
					cmd     = bba_pkg::CMD_F_MRG_STEP;
					state_d = S_F_MRG_TEST;
				end else begin
					cmd     = bba_pkg::CMD_F_SET;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// a register write restarts the clearing sweep
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	// state and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/bba_dpath.sv =====
// ----------------------------------------------------------------------------
// bba_dpath
// Datapath of the allocator: the free map memory (one bit per tree node,
// heap order), request registers, order and address counters, result regs.
// ----------------------------------------------------------------------------
module bba_dpath #(
	parameter int MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF,
	parameter int LEAF_COUNT = bba_pkg::LEAF_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cmd_t                 cmd,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          req_type,
	input  logic [bba_pkg::SIZE_W-1:0]    req_size,
	input  logic [bba_pkg::OFF_W-1:0]     block_offset,
	output bba_pkg::dp_stat_t             stat,
	output logic [bba_pkg::STATUS_W-1:0]  status,
	output logic [bba_pkg::OFF_W-1:0]     granted_offset,
	output logic [bba_pkg::SIZE_W-1:0]    granted_size
);

	localparam int H     = bba_pkg::tree_h(LEAF_COUNT);
	localparam int OW    = $clog2(H + 2);
	localparam int NW    = H + 1;
	localparam int PW    = H;
	localparam int MEM_D = (2 ** (H + 1)) - 1;
	// reciprocal of the minimum block for offset to leaf conversion
	localparam int RS    = bba_pkg::OFF_W + $clog2(MIN_BLOCK) + 1;
	localparam longint RECIP = ((64'd1 << RS) + MIN_BLOCK - 1) / MIN_BLOCK;

	logic mem [MEM_D];

	logic [bba_pkg::CFG_W-1:0]  pool_order_q;
	logic [NW-1:0]              clr_ptr_q;
	logic                       type_q;
	logic [bba_pkg::SIZE_W-1:0] size_q;
	logic [bba_pkg::OFF_W-1:0]  off_q;
	logic [bba_pkg::OFF_W-1:0]  qf_q;
	logic [OW-1:0]              k_q;
	logic [OW-1:0]              ord_q;
	logic [NW-1:0]              addr_q;
	logic [NW-1:0]              last_q;
	logic [PW-1:0]              pos_q;
	logic                       rd_q;
	logic [bba_pkg::STATUS_W-1:0] status_q;
	logic [bba_pkg::OFF_W-1:0]  goff_q;
	logic [bba_pkg::SIZE_W-1:0] gsize_q;

	logic [OW-1:0]  p;
	logic [OW-1:0]  k_c;
	logic           k_ok;
	logic           size_ok;
	logic [31:0]    prod;
	logic [31:0]    back;
	logic [31:0]    qmask;
	logic [31:0]    qend;
	logic           free_bad;
	logic [OW-1:0]  ord_inc;
	logic [NW-1:0]  desc_addr;
	logic           mem_we;
	logic [NW-1:0]  mem_wa;
	logic           mem_wd;

	// first node of order m in heap order
	function automatic logic [NW-1:0] base_of(input logic [OW-1:0] m);
		return (NW'(1) << (OW'(H) - m)) - NW'(1);
	endfunction

	// effective pool order, saturated at the tree height
	assign p = (pool_order_q > bba_pkg::CFG_W'(H)) ? OW'(H) : OW'(pool_order_q);

	// size to order: smallest order whose block holds the size
	always_comb begin
		k_c  = '0;
		k_ok = 1'b0;
		for (int j = H; j >= 0; j--) begin
			if ((OW'(j) <= p) && ((32'(MIN_BLOCK) << j) >= 32'(size_q))) begin
				k_c  = OW'(j);
				k_ok = 1'b1;
			end
		end
	end
	assign size_ok = k_ok && (size_q != '0);

	// free request checks: alignment and extent
	assign prod  = 32'(off_q) * 32'(RECIP);
	assign back  = 32'(qf_q) * 32'(MIN_BLOCK);
	assign qmask = (32'd1 << k_q) - 32'd1;
	assign qend  = 32'(qf_q) + (32'd1 << k_q);
	assign free_bad = !size_ok || (back != 32'(off_q)) || ((32'(qf_q) & qmask) != '0)
		|| (qend > (32'd1 << p));

	assign ord_inc   = ord_q + OW'(1);
	assign desc_addr = base_of(OW'(0)) + NW'(pos_q);

	// status to the controller
	assign stat.req_free      = (type_q == bba_pkg::REQ_FREE);
	assign stat.size_ok       = size_ok;
	assign stat.free_bad      = free_bad;
	assign stat.rd_free       = rd_q;
	assign stat.at_last       = (addr_q == last_q);
	assign stat.ord_eq_p      = (ord_q == p);
	assign stat.ord_gt_k      = (ord_q > k_q);
	assign stat.desc_last_ord = (ord_inc == k_q);
	assign stat.k_zero        = (k_q == '0);
	assign stat.clr_done      = (clr_ptr_q == NW'(MEM_D - 1));

	// free map write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = 1'b0;
		case (cmd)
			bba_pkg::CMD_CLR_STEP: begin
				mem_we = 1'b1;
				mem_wa = clr_ptr_q;
				mem_wd = (clr_ptr_q == base_of(p));
			end
			bba_pkg::CMD_A_TAKE: begin
				mem_we = 1'b1;
			end
			bba_pkg::CMD_A_SPLIT: begin
				mem_we = 1'b1;
				mem_wa = base_of(ord_q - OW'(1)) + NW'(pos_q >> (ord_q - OW'(1)))
					+ NW'(1);
				mem_wd = 1'b1;
			end
			bba_pkg::CMD_F_MRG_STEP: begin
				mem_we = 1'b1;
			end
			bba_pkg::CMD_F_SET: begin
				mem_we = 1'b1;
				mem_wa = base_of(ord_q) + NW'(pos_q >> ord_q);
				mem_wd = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// registered read of the current node
	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
	end

	// configuration and sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_order_q <= bba_pkg::POOL_ORDER_RST;
			clr_ptr_q    <= '0;
		end else if (cfg_we) begin
			pool_order_q <= cfg_wdata;
			clr_ptr_q    <= '0;
		end else if (cmd == bba_pkg::CMD_CLR_STEP) begin
			clr_ptr_q <= clr_ptr_q + NW'(1);
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			bba_pkg::CMD_LOAD: begin
				type_q <= req_type;
				size_q <= req_size;
				off_q  <= block_offset;
			end
			bba_pkg::CMD_PREP: begin
				k_q  <= k_c;
				qf_q <= bba_pkg::OFF_W'(prod >> RS);
			end
			bba_pkg::CMD_NEXT_ADDR: begin
				addr_q <= addr_q + NW'(1);
			end
			bba_pkg::CMD_A_INIT: begin
				ord_q  <= k_q;
				addr_q <= base_of(k_q);
				last_q <= base_of(k_q) + (NW'(1) << (p - k_q)) - NW'(1);
			end
			bba_pkg::CMD_A_NEXT_ORD: begin
				ord_q  <= ord_inc;
				addr_q <= base_of(ord_inc);
				last_q <= base_of(ord_inc) + (NW'(1) << (p - ord_inc)) - NW'(1);
			end
			bba_pkg::CMD_A_TAKE: begin
				pos_q <= PW'((addr_q - base_of(ord_q)) << ord_q);
			end
			bba_pkg::CMD_A_SPLIT: begin
				ord_q <= ord_q - OW'(1);
			end
			bba_pkg::CMD_F_ANC_INIT: begin
				pos_q  <= PW'(qf_q);
				ord_q  <= k_q;
				addr_q <= base_of(k_q) + NW'(PW'(qf_q) >> k_q);
			end
			bba_pkg::CMD_F_ANC_NEXT: begin
				ord_q  <= ord_inc;
				addr_q <= base_of(ord_inc) + NW'(pos_q >> ord_inc);
			end
			bba_pkg::CMD_F_DESC_INIT: begin
				ord_q  <= '0;
				addr_q <= desc_addr;
				last_q <= desc_addr + (NW'(1) << k_q) - NW'(1);
			end
			bba_pkg::CMD_F_DESC_NEXT_ORD: begin
				ord_q  <= ord_inc;
				addr_q <= base_of(ord_inc) + NW'(pos_q >> ord_inc);
				last_q <= base_of(ord_inc) + NW'(pos_q >> ord_inc)
					+ (NW'(1) << (k_q - ord_inc)) - NW'(1);
			end
			bba_pkg::CMD_F_MRG_INIT: begin
				ord_q  <= k_q;
				addr_q <= base_of(k_q) + NW'((pos_q >> k_q) ^ PW'(1));
			end
			bba_pkg::CMD_F_MRG_STEP: begin
				pos_q  <= pos_q & ~(PW'(1) << ord_q);
				ord_q  <= ord_inc;
				addr_q <= base_of(ord_inc) + NW'((pos_q >> ord_inc) ^ PW'(1));
			end
			bba_pkg::CMD_F_SET: begin
				status_q <= bba_pkg::ST_OK;
				goff_q   <= '0;
				gsize_q  <= '0;
			end
			bba_pkg::CMD_RES_ALLOC: begin
				status_q <= bba_pkg::ST_OK;
				goff_q   <= bba_pkg::OFF_W'(32'(pos_q) * 32'(MIN_BLOCK));
				gsize_q  <= bba_pkg::SIZE_W'(32'(MIN_BLOCK) << k_q);
			end
			bba_pkg::CMD_RES_NOFIT: begin
				status_q <= bba_pkg::ST_NOFIT;
				goff_q   <= '0;
				gsize_q  <= '0;
			end
			bba_pkg::CMD_RES_BAD: begin
				status_q <= bba_pkg::ST_BAD;
				goff_q   <= '0;
				gsize_q  <= '0;
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

	assign status         = status_q;
	assign granted_offset = goff_q;
	assign granted_size   = gsize_q;

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two pool of minimum-size blocks.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, req_size and block_offset while busy is
// low; the item is taken at that edge and busy rises. One result comes back
// per item: done is high for exactly one cycle with status, granted_offset
// and granted_size; the receiver cannot hold it off, and busy is low again
// in that cycle so the next item may be started at once.
// Sequence: each item passes the set-up steps (load, prepare, decide),
// then reads free-map nodes one at a time through the single registered
// read port of the free-map memory, each read followed by a check. An
// allocate reads nodes from the fitting order upward until a free one turns
// up, then splits it down to the fitting order; a free reads every enclosing
// node and every node inside the block, then merges with free buddies upward.
// Reset and a write of pool_order (cfg_we with cfg_wdata) start a clearing
// sweep over all 2^(H+1)-1 nodes (511 with 256 leaves) that leaves only the
// whole pool free; busy stays high during the sweep.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
	parameter int MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF,
	parameter int LEAF_COUNT = bba_pkg::LEAF_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [bba_pkg::SIZE_W-1:0]   req_size,
	input  logic [bba_pkg::OFF_W-1:0]    block_offset,
	input  logic                         cfg_we,
	input  logic [bba_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         done,
	output logic [bba_pkg::STATUS_W-1:0] status,
	output logic [bba_pkg::OFF_W-1:0]    granted_offset,
	output logic [bba_pkg::SIZE_W-1:0]   granted_size
);

	bba_pkg::cmd_t     cmd;
	bba_pkg::dp_stat_t stat;

	// sequencer
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// free map and arithmetic
	bba_dpath #(
		.MIN_BLOCK  (MIN_BLOCK),
		.LEAF_COUNT (LEAF_COUNT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_type       (req_type),
		.req_size       (req_size),
		.block_offset   (block_offset),
		.stat           (stat),
		.status         (status),
		.granted_offset (granted_offset),
		.granted_size   (granted_size)
	);

endmodule
